/* rtl/cau_pkg.sv */
package cau_pkg;

  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned FracBitsDef  = 16;

  typedef enum logic [2:0] {
    ACT_ADD  = 3'd0,
    ACT_SUB  = 3'd1,
    ACT_MUL  = 3'd2,
    ACT_DIV  = 3'd3,
    ACT_CONJ = 3'd4,
    ACT_MAG  = 3'd5
  } action_e;

endpackage

/* rtl/complex_arithmetic_unit.sv */
// Path: input, product and sum stages, stage 4, divider/root steps, output register.
// Throughput: one word per cycle; busy stays low, the pipeline never stalls.
// Depth is set by the restoring divider and square root, one quotient/root bit per stage.
// The receiver cannot stall: every result shows on valid_o for exactly one cycle.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; payload is not reset.
module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DataWidthDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   action_i,
  input  logic signed [DATA_WIDTH-1:0] a_re_i,
  input  logic signed [DATA_WIDTH-1:0] a_im_i,
  input  logic signed [DATA_WIDTH-1:0] b_re_i,
  input  logic signed [DATA_WIDTH-1:0] b_im_i,
  output logic                         valid_o,
  output logic signed [DATA_WIDTH-1:0] res_re_o,
  output logic signed [DATA_WIDTH-1:0] res_im_o,
  output logic                         div_zero_o,
  output logic                         overflowed_o
);

  localparam int unsigned W   = DATA_WIDTH;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned SW  = 2 * W + 1;
  localparam int unsigned Q   = W + 1;
  localparam int unsigned NW  = SW + F;
  localparam int unsigned CW  = NW + Q;
  localparam int unsigned RW  = Q + 2;
  localparam int unsigned LAT = W + 5;

  assign busy = 1'b0;

  // stage 1: input register
  logic                s1_valid_q, s1_dz_q;
  logic [2:0]          s1_act_q;
  logic signed [W-1:0] s1_ar_q, s1_ai_q, s1_br_q, s1_bi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_act_q <= action_i;
    s1_ar_q  <= a_re_i;
    s1_ai_q  <= a_im_i;
    s1_br_q  <= b_re_i;
    s1_bi_q  <= b_im_i;
    s1_dz_q  <= (action_i == ACT_DIV) && (b_re_i == '0) && (b_im_i == '0);
  end

  // stage 2: products
  logic                  s2_valid_q, s2_dz_q;
  logic [2:0]            s2_act_q;
  logic signed [W-1:0]   s2_ar_q, s2_ai_q, s2_br_q, s2_bi_q;
  logic signed [2*W-1:0] s2_p0_q, s2_p1_q, s2_p2_q, s2_p3_q, s2_p4_q, s2_p5_q;
  logic signed [W-1:0]   sq_x, sq_y;

  assign sq_x = (s1_act_q == ACT_DIV) ? s1_br_q : s1_ar_q;
  assign sq_y = (s1_act_q == ACT_DIV) ? s1_bi_q : s1_ai_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_act_q <= s1_act_q;
    s2_dz_q  <= s1_dz_q;
    s2_ar_q  <= s1_ar_q;
    s2_ai_q  <= s1_ai_q;
    s2_br_q  <= s1_br_q;
    s2_bi_q  <= s1_bi_q;
    s2_p0_q  <= s1_ar_q * s1_br_q;
    s2_p1_q  <= s1_ai_q * s1_bi_q;
    s2_p2_q  <= s1_ar_q * s1_bi_q;
    s2_p3_q  <= s1_ai_q * s1_br_q;
    s2_p4_q  <= sq_x * sq_x;
    s2_p5_q  <= sq_y * sq_y;
  end

  // stage 3: sums
  logic                 s3_valid_q, s3_dz_q;
  logic [2:0]           s3_act_q;
  logic signed [SW-1:0] s3_nre_q, s3_nim_q;
  logic [SW-1:0]        s3_sq_q;
  logic signed [W:0]    s3_sre_q, s3_sim_q;
  logic signed [W:0]    sre_d, sim_d;

  always_comb begin
    unique case (s2_act_q)
      ACT_ADD: begin
        sre_d = (W+1)'(s2_ar_q) + (W+1)'(s2_br_q);
        sim_d = (W+1)'(s2_ai_q) + (W+1)'(s2_bi_q);
      end
      ACT_SUB: begin
        sre_d = (W+1)'(s2_ar_q) - (W+1)'(s2_br_q);
        sim_d = (W+1)'(s2_ai_q) - (W+1)'(s2_bi_q);
      end
      ACT_CONJ: begin
        sre_d = (W+1)'(s2_ar_q);
        sim_d = -(W+1)'(s2_ai_q);
      end
      default: begin
        sre_d = '0;
        sim_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_act_q <= s2_act_q;
    s3_dz_q  <= s2_dz_q;
    s3_sre_q <= sre_d;
    s3_sim_q <= sim_d;
    s3_sq_q  <= SW'($unsigned(s2_p4_q)) + SW'($unsigned(s2_p5_q));
    if (s2_act_q == ACT_DIV) begin
      s3_nre_q <= SW'(s2_p0_q) + SW'(s2_p1_q);
      s3_nim_q <= SW'(s2_p3_q) - SW'(s2_p2_q);
    end else begin
      s3_nre_q <= SW'(s2_p0_q) - SW'(s2_p1_q);
      s3_nim_q <= SW'(s2_p2_q) + SW'(s2_p3_q);
    end
  end

  // stage 4 feeds stage array index 0; divider/root steps fill indexes 1..Q
  logic          v_q   [Q+1];
  logic          dz_q  [Q+1];
  logic [2:0]    act_q [Q+1];
  logic          ngr_q [Q+1];
  logic          ngi_q [Q+1];
  logic          ovr_q [Q+1];
  logic          ovi_q [Q+1];
  logic [SW-1:0] mgr_q [Q+1];
  logic [SW-1:0] mgi_q [Q+1];
  logic [NW-1:0] nr_q  [Q+1];
  logic [NW-1:0] ni_q  [Q+1];
  logic [SW-1:0] den_q [Q+1];
  logic [SW-1:0] rr_q  [Q+1];
  logic [SW-1:0] ri_q  [Q+1];
  logic [Q-1:0]  qr_q  [Q+1];
  logic [Q-1:0]  qi_q  [Q+1];
  logic [2*Q-1:0] sn_q [Q+1];
  logic [RW-1:0] srm_q [Q+1];
  logic [Q-1:0]  rt_q  [Q+1];

  logic          abs_nr_neg, abs_ni_neg;
  logic [SW-1:0] abs_nr, abs_ni, abs_sr, abs_si;
  logic [NW-1:0] n4r, n4i;

  assign abs_nr_neg = s3_nre_q[SW-1];
  assign abs_ni_neg = s3_nim_q[SW-1];
  assign abs_nr = abs_nr_neg ? SW'(-s3_nre_q) : SW'(s3_nre_q);
  assign abs_ni = abs_ni_neg ? SW'(-s3_nim_q) : SW'(s3_nim_q);
  assign abs_sr = s3_sre_q[W] ? SW'($unsigned(-s3_sre_q)) : SW'($unsigned(s3_sre_q));
  assign abs_si = s3_sim_q[W] ? SW'($unsigned(-s3_sim_q)) : SW'($unsigned(s3_sim_q));
  assign n4r = NW'(abs_nr) << F;
  assign n4i = NW'(abs_ni) << F;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q[0] <= s3_act_q;
    dz_q[0]  <= s3_dz_q;
    nr_q[0]  <= n4r;
    ni_q[0]  <= n4i;
    den_q[0] <= s3_sq_q;
    rr_q[0]  <= SW'(n4r >> Q);
    ri_q[0]  <= SW'(n4i >> Q);
    qr_q[0]  <= '0;
    qi_q[0]  <= '0;
    sn_q[0]  <= (2*Q)'(s3_sq_q);
    srm_q[0] <= '0;
    rt_q[0]  <= '0;
    ovr_q[0] <= (s3_act_q == ACT_DIV) && (CW'(n4r) >= (CW'(s3_sq_q) << Q));
    ovi_q[0] <= (s3_act_q == ACT_DIV) && (CW'(n4i) >= (CW'(s3_sq_q) << Q));
    unique case (s3_act_q)
      ACT_MUL: begin
        ngr_q[0] <= abs_nr_neg;
        ngi_q[0] <= abs_ni_neg;
        mgr_q[0] <= abs_nr >> F;
        mgi_q[0] <= abs_ni >> F;
      end
      ACT_DIV: begin
        ngr_q[0] <= abs_nr_neg;
        ngi_q[0] <= abs_ni_neg;
        mgr_q[0] <= '0;
        mgi_q[0] <= '0;
      end
      ACT_ADD, ACT_SUB, ACT_CONJ: begin
        ngr_q[0] <= s3_sre_q[W];
        ngi_q[0] <= s3_sim_q[W];
        mgr_q[0] <= abs_sr;
        mgi_q[0] <= abs_si;
      end
      default: begin
        ngr_q[0] <= 1'b0;
        ngi_q[0] <= 1'b0;
        mgr_q[0] <= '0;
        mgi_q[0] <= '0;
      end
    endcase
  end

  for (genvar i = 0; i < Q; i++) begin : g_stg
    logic [SW:0]   dr, di;
    logic          ger, gei;
    logic [RW+1:0] st, trial;
    logic          ges;

    assign dr    = {rr_q[i], nr_q[i][Q-1-i]};
    assign di    = {ri_q[i], ni_q[i][Q-1-i]};
    assign ger   = dr >= {1'b0, den_q[i]};
    assign gei   = di >= {1'b0, den_q[i]};
    assign st    = {srm_q[i], sn_q[i][2*Q-1-2*i -: 2]};
    assign trial = (RW+2)'({rt_q[i], 2'b01});
    assign ges   = st >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      act_q[i+1] <= act_q[i];
      dz_q[i+1]  <= dz_q[i];
      ngr_q[i+1] <= ngr_q[i];
      ngi_q[i+1] <= ngi_q[i];
      ovr_q[i+1] <= ovr_q[i];
      ovi_q[i+1] <= ovi_q[i];
      mgr_q[i+1] <= mgr_q[i];
      mgi_q[i+1] <= mgi_q[i];
      nr_q[i+1]  <= nr_q[i];
      ni_q[i+1]  <= ni_q[i];
      den_q[i+1] <= den_q[i];
      sn_q[i+1]  <= sn_q[i];
      rr_q[i+1]  <= ger ? SW'(dr - {1'b0, den_q[i]}) : SW'(dr);
      ri_q[i+1]  <= gei ? SW'(di - {1'b0, den_q[i]}) : SW'(di);
      qr_q[i+1]  <= {qr_q[i][Q-2:0], ger};
      qi_q[i+1]  <= {qi_q[i][Q-2:0], gei};
      srm_q[i+1] <= ges ? RW'(st - trial) : RW'(st);
      rt_q[i+1]  <= {rt_q[i][Q-2:0], ges};
    end
  end

  // select and saturate
  localparam logic [SW-1:0] Lim = SW'(1) << (W - 1);
  localparam logic signed [W-1:0] MaxVal = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MinVal = {1'b1, {(W-1){1'b0}}};

  logic          f_ngr, f_ngi, f_ovr, f_ovi;
  logic [SW-1:0] f_mgr, f_mgi;
  logic signed [W-1:0] f_re, f_im;

  always_comb begin
    f_ngr = ngr_q[Q];
    f_ngi = ngi_q[Q];
    f_mgr = mgr_q[Q];
    f_mgi = mgi_q[Q];
    f_ovr = ovr_q[Q];
    f_ovi = ovi_q[Q];
    if (act_q[Q] == ACT_DIV) begin
      if (dz_q[Q]) begin
        f_ngr = 1'b0;
        f_ngi = 1'b0;
        f_mgr = '0;
        f_mgi = '0;
        f_ovr = 1'b0;
        f_ovi = 1'b0;
      end else begin
        f_mgr = SW'(qr_q[Q]);
        f_mgi = SW'(qi_q[Q]);
      end
    end else if (act_q[Q] == ACT_MAG) begin
      f_ngr = 1'b0;
      f_ngi = 1'b0;
      f_mgr = SW'(rt_q[Q]);
      f_mgi = '0;
    end
    f_ovr = f_ovr | (f_ngr ? (f_mgr > Lim) : (f_mgr >= Lim));
    f_ovi = f_ovi | (f_ngi ? (f_mgi > Lim) : (f_mgi >= Lim));
    if (f_ovr) begin
      f_re = f_ngr ? MinVal : MaxVal;
    end else begin
      f_re = f_ngr ? -W'(f_mgr) : W'(f_mgr);
    end
    if (f_ovi) begin
      f_im = f_ngi ? MinVal : MaxVal;
    end else begin
      f_im = f_ngi ? -W'(f_mgi) : W'(f_mgi);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= v_q[Q];
    end
  end

  always_ff @(posedge clk_i) begin
    res_re_o     <= f_re;
    res_im_o     <= f_im;
    div_zero_o   <= (act_q[Q] == ACT_DIV) && dz_q[Q];
    overflowed_o <= f_ovr | f_ovi;
  end

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start, LAT + 1))
    else $error("result without a matching accepted word");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && div_zero_o) |-> (res_re_o == '0 && res_im_o == '0 && !overflowed_o))
    else $error("divide by zero gave nonzero result");

  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && overflowed_o) |-> (res_re_o == MaxVal || res_re_o == MinVal ||
                                   res_im_o == MaxVal || res_im_o == MinVal))
    else $error("overflow flagged without a saturated part");

endmodule
